// File: rtl/hbs_pkg.sv
// Package for the heightmap bilinear sampler: field widths, register indexes,
// command codes and sequencer states. No dependencies.
package hbs_pkg;

  localparam int HEIGHT_W        = 16;
  localparam int COORD_W         = 32;
  localparam int SCALE_W         = 24;
  localparam int ORIGIN_W        = 16;
  localparam int CFG_DATA_W      = 24;
  localparam int CFG_INDEX_W     = 2;
  localparam int FIELD_IDX_W     = 6;
  localparam int WEIGHT_W        = 17;
  localparam int GRID_POINTS_DEF = 33;

  localparam logic [SCALE_W-1:0]  SCALE_RESET = 24'h01_0000;  // 1.0 in Q8.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h1_0000;   // 1.0 in Q1.16

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SCALE      = 2'd0,
    CFG_ORIGIN_COL = 2'd1,
    CFG_ORIGIN_ROW = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LOCATE,
    ST_READ,
    ST_ROW,
    ST_COL,
    ST_DONE
  } state_t;

endpackage

// File: rtl/heightmap_bilinear_sampler.sv
// Top level of the heightmap bilinear sampler: transaction sequencer, scale and
// blend datapath, output register. Depends on hbs_pkg and hbs_grid_mem.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------------
//  in      | in_valid / in_stall    | in_cmd, in_write_col, in_write_row,
//          |                        | in_write_height, in_world_x, in_world_y
//  out     | out_valid / out_stall  | out_sampled_height, out_outside
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction is in flight at a time. A sample passes from acceptance
// through scale multiply, locate, bank read, row blend, column blend and round
// into the output register; a write commits in the scale step and skips ahead.
// The sequencer, with its one shared pass through these stages, sets the rate.
// The output register lets the next transaction be accepted while a result waits.
// rst_n is synchronous, active low; the height store is not cleared.
// Config writes are always taken (cfg_ready is tied high).
module heightmap_bilinear_sampler import hbs_pkg::*; #(
  parameter int GRID_POINTS = GRID_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [FIELD_IDX_W-1:0]     in_write_col,
  input  logic [FIELD_IDX_W-1:0]     in_write_row,
  input  logic signed [HEIGHT_W-1:0] in_write_height,
  input  logic [COORD_W-1:0]         in_world_x,
  input  logic [COORD_W-1:0]         in_world_y,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [HEIGHT_W-1:0] out_sampled_height,
  output logic                       out_outside,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // grid geometry
  localparam int IW    = $clog2(GRID_POINTS);       // corner index width
  localparam int HALF  = (GRID_POINTS + 1) / 2;     // rows/cols per parity bank
  localparam int DEPTH = HALF * HALF;               // entries per bank
  localparam int AW    = $clog2(DEPTH);
  localparam int PROD_W = COORD_W + SCALE_W;        // Q24.32 grid coordinate
  localparam logic [23:0]   LAST_LINE = 24'(GRID_POINTS - 1);
  localparam logic [IW-1:0] LAST_CELL = IW'(GRID_POINTS - 2);

  typedef struct packed {
    logic [IW-1:0]       pos;
    logic [WEIGHT_W-1:0] weight;
    logic                clamped;
  } loc_t;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [SCALE_W-1:0]  scale_r;
  logic [ORIGIN_W-1:0] origin_col_r;
  logic [ORIGIN_W-1:0] origin_row_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= SCALE_RESET;
      origin_col_r <= '0;
      origin_row_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE:      scale_r      <= cfg_data;
        CFG_ORIGIN_COL: origin_col_r <= cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_ROW: origin_row_r <= cfg_data[ORIGIN_W-1:0];
        default:        ;  // unmapped index, dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------
  state_t state_r, state_nxt;
  logic   in_accept;
  logic   mem_we;
  logic   out_load;
  logic   out_valid_r, out_valid_nxt;

  // captured transaction
  logic                       item_cmd_r;
  logic [FIELD_IDX_W-1:0]     item_col_r;
  logic [FIELD_IDX_W-1:0]     item_row_r;
  logic [HEIGHT_W-1:0]        item_height_r;
  logic [COORD_W-1:0]         item_x_r;
  logic [COORD_W-1:0]         item_y_r;

  logic write_in_range;

  assign write_in_range = (32'(item_col_r) < 32'(GRID_POINTS)) &&
                          (32'(item_row_r) < 32'(GRID_POINTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        // a write commits here and skips straight to the result
        if (item_cmd_r == CMD_WRITE) begin
          mem_we    = write_in_range;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_LOCATE;
        end
      end
      ST_LOCATE: state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_ROW;
      ST_ROW:    state_nxt = ST_COL;
      ST_COL:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_cmd_r    <= in_cmd;
      item_col_r    <= in_write_col;
      item_row_r    <= in_write_row;
      item_height_r <= in_write_height;
      item_x_r      <= in_world_x;
      item_y_r      <= in_world_y;
    end
  end

  // ------------------------------------------------------------------
  // scale: world Q16.16 times scale Q8.16 -> grid Q24.32
  // ------------------------------------------------------------------
  logic [PROD_W-1:0] prod_x_r, prod_y_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      prod_x_r <= PROD_W'(item_x_r) * PROD_W'(scale_r);
      prod_y_r <= PROD_W'(item_y_r) * PROD_W'(scale_r);
    end
  end

  // ------------------------------------------------------------------
  // locate: patch-local cell and weight, clamp to the border
  // ------------------------------------------------------------------
  function automatic loc_t locate(input logic [PROD_W-1:0] prod,
                                  input logic [ORIGIN_W-1:0] origin);
    logic [23:0] whole;
    logic [15:0] frac;
    logic [23:0] local_pos;
    logic        below;
    logic        beyond;
    logic        at_last;
    loc_t        res;
    whole     = prod[55:32];
    frac      = prod[31:16];
    below     = whole < 24'(origin);
    local_pos = whole - 24'(origin);
    beyond    = !below && ((local_pos > LAST_LINE) ||
                           ((local_pos == LAST_LINE) && (frac != 16'h0)));
    at_last   = !below && (local_pos >= LAST_LINE);
    if (below) begin
      res.pos    = '0;
      res.weight = '0;
    end else if (at_last) begin
      // far line: last cell, full weight on its far corner
      res.pos    = LAST_CELL;
      res.weight = WEIGHT_ONE;
    end else begin
      res.pos    = local_pos[IW-1:0];
      res.weight = {1'b0, frac};
    end
    res.clamped = below || beyond;
    return res;
  endfunction

  loc_t loc_x, loc_y;
  logic [IW-1:0]       cx_r, cy_r;
  logic [WEIGHT_W-1:0] wx_r, wy_r;
  logic                outside_r;

  assign loc_x = locate(prod_x_r, origin_col_r);
  assign loc_y = locate(prod_y_r, origin_row_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_LOCATE) begin
      cx_r      <= loc_x.pos;
      cy_r      <= loc_y.pos;
      wx_r      <= loc_x.weight;
      wy_r      <= loc_y.weight;
      outside_r <= loc_x.clamped || loc_y.clamped;
    end
  end

  // ------------------------------------------------------------------
  // parity banked store: bank index is {row[0], col[0]}
  // ------------------------------------------------------------------
  logic [IW-1:0]             wr_col_idx, wr_row_idx;
  logic [AW-1:0]             wr_addr;
  logic [1:0]                wr_bank;
  logic [IW-1:0]             col_even_h, col_odd_h, row_even_h, row_odd_h;
  logic [3:0][AW-1:0]        rd_addr;
  logic [3:0][HEIGHT_W-1:0]  rd_data;

  assign wr_col_idx = IW'(item_col_r);
  assign wr_row_idx = IW'(item_row_r);
  assign wr_bank    = {wr_row_idx[0], wr_col_idx[0]};
  assign wr_addr    = AW'(32'(wr_row_idx >> 1) * HALF + 32'(wr_col_idx >> 1));

  // the even one of cx / cx+1 sits one half-step up when cx is odd
  assign col_even_h = (cx_r >> 1) + IW'(cx_r[0]);
  assign col_odd_h  = cx_r >> 1;
  assign row_even_h = (cy_r >> 1) + IW'(cy_r[0]);
  assign row_odd_h  = cy_r >> 1;

  assign rd_addr[0] = AW'(32'(row_even_h) * HALF + 32'(col_even_h));
  assign rd_addr[1] = AW'(32'(row_even_h) * HALF + 32'(col_odd_h));
  assign rd_addr[2] = AW'(32'(row_odd_h)  * HALF + 32'(col_even_h));
  assign rd_addr[3] = AW'(32'(row_odd_h)  * HALF + 32'(col_odd_h));

  hbs_grid_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_grid_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (item_height_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ------------------------------------------------------------------
  // row blend: h = c0 * 2^16 + (c1 - c0) * wx, exact in Q.16
  // ------------------------------------------------------------------
  logic signed [HEIGHT_W-1:0] c00, c10, c01, c11;
  logic signed [16:0]         d0, d1;
  logic signed [34:0]         h0_full, h1_full;
  logic signed [31:0]         h0_r, h1_r;

  assign c00 = $signed(rd_data[{cy_r[0],  cx_r[0]}]);
  assign c10 = $signed(rd_data[{cy_r[0], ~cx_r[0]}]);
  assign c01 = $signed(rd_data[{~cy_r[0],  cx_r[0]}]);
  assign c11 = $signed(rd_data[{~cy_r[0], ~cx_r[0]}]);

  assign d0 = 17'(c10) - 17'(c00);
  assign d1 = 17'(c11) - 17'(c01);
  assign h0_full = (35'(c00) <<< 16) + d0 * $signed({1'b0, wx_r});
  assign h1_full = (35'(c01) <<< 16) + d1 * $signed({1'b0, wx_r});

  always_ff @(posedge clk) begin
    if (state_r == ST_ROW) begin
      h0_r <= h0_full[31:0];
      h1_r <= h1_full[31:0];
    end
  end

  // ------------------------------------------------------------------
  // column blend in Q.32; a write leaves zero here
  // ------------------------------------------------------------------
  logic signed [32:0] dh;
  logic signed [49:0] h_full;
  logic signed [49:0] h_r;
  logic               flag_r;

  assign dh     = 33'(h1_r) - 33'(h0_r);
  assign h_full = (50'(h0_r) <<< 16) + dh * $signed({1'b0, wy_r});

  always_ff @(posedge clk) begin
    if (state_r == ST_COL) begin
      h_r    <= h_full;
      flag_r <= outside_r;
    end else if (state_r == ST_SCALE) begin
      h_r    <= '0;
      flag_r <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // round half up and hold in the output register
  // ------------------------------------------------------------------
  logic signed [49:0]         h_biased;
  logic signed [HEIGHT_W-1:0] height_r;
  logic                       outside_out_r;

  assign h_biased = h_r + 50'sh8000_0000;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      height_r      <= h_biased[47:32];
      outside_out_r <= flag_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sampled_height = height_r;
  assign out_outside        = outside_out_r;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  a_store_write_only_for_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SCALE) && (item_cmd_r == CMD_WRITE))
    else $error("height store written outside a write transaction");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r) == ST_DONE)
    else $error("result raised without a finished transaction");

  a_weights_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |-> (wx_r <= WEIGHT_ONE) && (wy_r <= WEIGHT_ONE) &&
                           (cx_r <= LAST_CELL) && (cy_r <= LAST_CELL))
    else $error("cell or weight out of the patch");

  a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_SCALE) && !in_accept)
    else $error("transaction accepted while one is in flight");

endmodule

// File: rtl/hbs_grid_mem.sv
// Height store split into four banks by row and column parity, so the four
// corners of any cell are read together, one from each bank. Depends on hbs_pkg.
module hbs_grid_mem import hbs_pkg::*; #(
  parameter int DEPTH = 289,
  parameter int AW    = 9
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_bank,
  input  logic [AW-1:0]                wr_addr,
  input  logic [HEIGHT_W-1:0]          wr_data,
  input  logic [3:0][AW-1:0]           rd_addr,
  output logic [3:0][HEIGHT_W-1:0]     rd_data
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [HEIGHT_W-1:0] mem [DEPTH];
    logic [HEIGHT_W-1:0] rd_data_r;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      rd_data_r <= mem[rd_addr[b]];
    end

    assign rd_data[b] = rd_data_r;
  end

endmodule

// File: bench/hbs_checker.sv
// Scoreboard for the heightmap bilinear sampler bench: mirrors config and height
// writes, predicts every transaction's result and compares it. Depends on hbs_pkg.
`timescale 1ns / 100ps
module hbs_checker import hbs_pkg::*; #(
  parameter int GRID_POINTS = GRID_POINTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [FIELD_IDX_W-1:0]     in_write_col,
  input  logic [FIELD_IDX_W-1:0]     in_write_row,
  input  logic signed [HEIGHT_W-1:0] in_write_height,
  input  logic [COORD_W-1:0]         in_world_x,
  input  logic [COORD_W-1:0]         in_world_y,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [HEIGHT_W-1:0] out_sampled_height,
  input  logic                       out_outside,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         outstanding,
  output int                         fail_count
);

  localparam int     LAST        = GRID_POINTS - 1;
  localparam int     MAX_REPORTS = 100;
  localparam longint ROUND_BIAS  = 64'sd2147483648;  // one half in Q.32

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height;
    logic                       outside;
  } sample_result_t;

  logic [SCALE_W-1:0]         scale_reg;
  logic [ORIGIN_W-1:0]        col_origin;
  logic [ORIGIN_W-1:0]        row_origin;
  logic signed [HEIGHT_W-1:0] heights [GRID_POINTS*GRID_POINTS];
  sample_result_t             awaited_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_REPORTS)
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic longint corner(input int col, input int row);
    return longint'(heights[row * GRID_POINTS + col]);
  endfunction

  // world -> patch cell and weight; returns 1 when clamped
  function automatic logic clamp_axis(input logic [COORD_W-1:0] world,
                                      input logic [ORIGIN_W-1:0] origin,
                                      output int pos, output logic [WEIGHT_W-1:0] weight);
    logic [55:0]         prod;
    logic [15:0]         frac;
    longint              lcl;
    logic                clamped;
    prod    = 56'(world) * 56'(scale_reg);
    frac    = prod[31:16];
    lcl     = longint'(prod[55:32]) - longint'(origin);
    clamped = 1'b0;
    if (lcl < 0) begin
      lcl     = 0;
      frac    = '0;
      clamped = 1'b1;
    end else if (lcl > LAST || (lcl == LAST && frac != 0)) begin
      lcl     = LAST;
      frac    = '0;
      clamped = 1'b1;
    end
    // far edge: last cell at full weight
    if (lcl == LAST) begin
      pos    = LAST - 1;
      weight = WEIGHT_ONE;
    end else begin
      pos    = int'(lcl);
      weight = {1'b0, frac};
    end
    return clamped;
  endfunction

  function automatic sample_result_t predict_result();
    sample_result_t      r;
    int                  cx, cy;
    logic [WEIGHT_W-1:0] wx, wy;
    logic                clamp_x, clamp_y;
    longint              wxl, wyl, h0, h1, blend, rounded;
    r = '0;
    if (in_cmd == CMD_WRITE) begin
      if (int'(in_write_col) < GRID_POINTS && int'(in_write_row) < GRID_POINTS)
        heights[int'(in_write_row) * GRID_POINTS + int'(in_write_col)] = in_write_height;
      return r;
    end
    clamp_x = clamp_axis(in_world_x, col_origin, cx, wx);
    clamp_y = clamp_axis(in_world_y, row_origin, cy, wy);
    wxl     = longint'(wx);
    wyl     = longint'(wy);
    h0      = corner(cx, cy) * (65536 - wxl) + corner(cx + 1, cy) * wxl;
    h1      = corner(cx, cy + 1) * (65536 - wxl) + corner(cx + 1, cy + 1) * wxl;
    blend   = h0 * (65536 - wyl) + h1 * wyl;
    rounded = (blend + ROUND_BIAS) >>> 32;
    r.height  = rounded[HEIGHT_W-1:0];
    r.outside = clamp_x | clamp_y;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sample_result_t want;
    if (!rst_n) begin
      scale_reg  = SCALE_RESET;
      col_origin = '0;
      row_origin = '0;
      awaited_q.delete();
      fail_count  = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE:      scale_reg  = cfg_data[SCALE_W-1:0];
          CFG_ORIGIN_COL: col_origin = cfg_data[ORIGIN_W-1:0];
          CFG_ORIGIN_ROW: row_origin = cfg_data[ORIGIN_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting: a result can never belong to this edge's input
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("unexpected result, height", int'(out_sampled_height), 0);
        end else begin
          want = awaited_q.pop_front();
          if (out_sampled_height !== want.height)
            report_mismatch("sampled_height", int'(out_sampled_height),
                            int'(want.height));
          if (out_outside !== want.outside)
            report_mismatch("outside", int'(out_outside), int'(want.outside));
        end
      end
      if (in_valid && !in_stall)
        awaited_q.push_back(predict_result());
      outstanding <= awaited_q.size();
    end
  end

endmodule

// File: bench/testbench.sv
// Top of the heightmap bilinear sampler bench: clock, reset, config writes and
// transaction stimulus with random idling; verdict from hbs_checker. Uses hbs_pkg.
`timescale 1ns / 100ps
module testbench;
  import hbs_pkg::*;

  localparam int GP              = GRID_POINTS_DEF;
  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 16;       // longer than one sample's pass through the block
  localparam int HOLD_CYCLES     = 400;      // long receiver hold-off
  localparam int ITEMS_PER_PHASE = 140;
  localparam int NUM_PHASES      = 6;
  localparam int CYCLE_LIMIT     = 1000000;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       in_valid        = 1'b0;
  logic                       in_stall;
  cmd_t                       in_cmd          = CMD_WRITE;
  logic [FIELD_IDX_W-1:0]     in_write_col    = '0;
  logic [FIELD_IDX_W-1:0]     in_write_row    = '0;
  logic signed [HEIGHT_W-1:0] in_write_height = '0;
  logic [COORD_W-1:0]         in_world_x      = '0;
  logic [COORD_W-1:0]         in_world_y      = '0;
  logic                       out_valid;
  logic                       out_stall       = 1'b0;
  logic signed [HEIGHT_W-1:0] out_sampled_height;
  logic                       out_outside;
  logic                       cfg_valid       = 1'b0;
  logic                       cfg_ready;
  cfg_reg_t                   cfg_index       = CFG_SCALE;
  logic [CFG_DATA_W-1:0]      cfg_data        = '0;
  int                         outstanding;
  int                         fail_count;

  // stimulus-side copy of the current setting, used only to aim positions
  logic [SCALE_W-1:0]  cur_scale      = SCALE_RESET;
  logic [ORIGIN_W-1:0] cur_col_origin = '0;
  logic [ORIGIN_W-1:0] cur_row_origin = '0;
  bit                  calm           = 1'b0;   // no idling on either side
  logic                hold_go        = 1'b0;   // request for the long hold-off
  int                  cycles         = 0;

  always #5 clk = ~clk;

  heightmap_bilinear_sampler #(.GRID_POINTS(GP)) uut (.*);

  hbs_checker #(.GRID_POINTS(GP)) scoreboard (.*);

  // Hard stop: far beyond the slowest legal run (max gaps, max stalls, hold-off).
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none while calm.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] random_height();
    if ($urandom_range(0, 7) == 0)
      return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    return HEIGHT_W'($urandom);
  endfunction

  // Pick a world coordinate aimed at the patch under the current
  // setting: a random line, with a zero, full or random fraction. Falls back
  // to noise when the patch cannot be reached (zero scale, origin too high).
  function automatic logic [COORD_W-1:0] aim_axis(input logic [ORIGIN_W-1:0] origin);
    longint unsigned goal, world;
    int              lc;
    logic [15:0]     frac;
    lc = $urandom_range(0, GP - 1);
    case ($urandom_range(0, 3))
      0:       frac = '0;
      1:       frac = 16'hFFFF;
      default: frac = 16'($urandom);
    endcase
    if (lc == GP - 1 && $urandom_range(0, 1) == 1) frac = '0;  // right on the far edge
    if (cur_scale == 0) return $urandom;
    goal  = ((longint'(origin) + lc) << 32) | (longint'(frac) << 16);
    world = (goal + cur_scale - 1) / cur_scale;
    if (world > 64'hFFFF_FFFF) return $urandom;
    return world[COORD_W-1:0];
  endfunction

  // Offer one transaction and hold it until taken. Entered and left right
  // after a rising edge; valid stays high into the next transaction.
  task automatic send_item(input cmd_t cmd, input logic [FIELD_IDX_W-1:0] col,
                           input logic [FIELD_IDX_W-1:0] row,
                           input logic signed [HEIGHT_W-1:0] h,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_write_col    <= col;
    in_write_row    <= row;
    in_write_height <= h;
    in_world_x      <= x;
    in_world_y      <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // unused fields carry junk so their bits toggle too
  task automatic write_height_at(input int col, input int row,
                                 input logic signed [HEIGHT_W-1:0] h);
    send_item(CMD_WRITE, FIELD_IDX_W'(col), FIELD_IDX_W'(row), h, $urandom, $urandom);
  endtask

  task automatic sample_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    send_item(CMD_SAMPLE, FIELD_IDX_W'($urandom), FIELD_IDX_W'($urandom),
              HEIGHT_W'($urandom), x, y);
  endtask

  // Stop offering, wait until every result is back, then let the pipe settle.
  // The extra edge first lets the scoreboard count the last acceptance.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic set_config(input logic [SCALE_W-1:0] scale,
                            input logic [ORIGIN_W-1:0] ocol,
                            input logic [ORIGIN_W-1:0] orow);
    cfg_reg_t              regs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    regs = '{CFG_SCALE, CFG_ORIGIN_COL, CFG_ORIGIN_ROW};
    vals = '{scale, CFG_DATA_W'(ocol), CFG_DATA_W'(orow)};
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid      <= 1'b0;
    cur_scale      = scale;
    cur_col_origin = ocol;
    cur_row_origin = orow;
  endtask

  // Mix: writes (some off the grid, ignored), aimed samples, half-aimed
  // samples and pure noise that mostly clamps.
  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)
      write_height_at($urandom_range(0, 63), $urandom_range(0, 63), random_height());
    else if (pick < 20)
      write_height_at($urandom_range(0, GP - 1), $urandom_range(0, GP - 1), random_height());
    else if (pick < 78)
      sample_at(aim_axis(cur_col_origin), aim_axis(cur_row_origin));
    else if (pick < 88)
      sample_at(aim_axis(cur_col_origin), $urandom);
    else
      sample_at($urandom, $urandom);
  endtask

  // Result side: random stall runs, plus one long hold-off on request while
  // the sender keeps offering, so the block backs up and stalls its input.
  initial begin : result_sink
    int   stall_len;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stall_len = pick_gap();
        out_stall <= (stall_len != 0);
        repeat (stall_len == 0 ? $urandom_range(1, 8) : stall_len) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [SCALE_W-1:0]  phase_scale [NUM_PHASES];
    logic [ORIGIN_W-1:0] phase_col   [NUM_PHASES];
    logic [ORIGIN_W-1:0] phase_row   [NUM_PHASES];

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit scale, patch at terrain origin
    set_config(SCALE_RESET, 16'd0, 16'd0);

    // Fill pass: every grid entry gets a height before any sample can read it.
    for (int r = 0; r < GP; r++)
      for (int c = 0; c < GP; c++)
        write_height_at(c, r, random_height());

    // ---- directed ----
    // flat cell at the positive extreme
    write_height_at(10, 10, 16'sh7FFF);
    write_height_at(11, 10, 16'sh7FFF);
    write_height_at(10, 11, 16'sh7FFF);
    write_height_at(11, 11, 16'sh7FFF);
    sample_at(32'h000A_8000, 32'h000A_8000);
    // opposite extremes at half weight: exact -0.5 rounds up to 0
    write_height_at(20, 20, 16'sh8000);
    write_height_at(21, 20, 16'sh7FFF);
    write_height_at(20, 21, 16'sh8000);
    write_height_at(21, 21, 16'sh7FFF);
    sample_at(32'h0014_8000, 32'h0014_4000);
    // writes off the grid are dropped, still answer 0
    write_height_at(GP, 0, 16'sh1234);
    write_height_at(63, 63, -16'sd1);
    write_height_at(0, 40, 16'sh0F0F);
    // near corner, then far edge exactly on the last line (not clamped)
    sample_at(32'h0000_0000, 32'h0000_0000);
    write_height_at(GP - 1, GP - 1, 16'sh8000);
    sample_at(32'h0020_0000, 32'h0020_0000);
    // one LSB past the far edge, and the coordinate maximum: clamped
    sample_at(32'h0020_0001, 32'h0005_0000);
    sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // just under the far edge, a tiny fraction and a near-full fraction
    sample_at(32'h001F_FFFF, 32'h0000_0000);
    sample_at(32'h000C_0001, 32'h0000_FFFF);

    // zero scale: everything collapses onto terrain grid 0
    set_config(24'd0, 16'd0, 16'd0);
    sample_at(32'hFFFF_FFFF, 32'h0000_0001);
    sample_at(32'h1234_5678, 32'h8765_4321);

    // patch above the small positions: below the patch on both axes, then exactly on its origin
    set_config(SCALE_RESET, 16'd100, 16'hFFFF);
    sample_at(32'h0000_0000, 32'h0000_0000);
    sample_at(32'h0064_0000, 32'hFFFF_0000);

    // ---- random phases, extremes of every register among them ----
    phase_scale = '{SCALE_RESET, 24'd0, 24'hFF_FFFF, 24'h00_8000, 24'h03_0000, 24'd0};
    phase_col   = '{16'd0, 16'd0, 16'hFFFF, 16'd5, 16'hFFFF, 16'd0};
    phase_row   = '{16'd0, 16'd0, 16'hFFF0, 16'd0, 16'hFFFF, 16'd0};
    phase_scale[NUM_PHASES-1] = SCALE_W'($urandom_range(24'h00_4000, 24'h40_0000));
    phase_col[NUM_PHASES-1]   = ORIGIN_W'($urandom_range(0, 2000));
    phase_row[NUM_PHASES-1]   = ORIGIN_W'($urandom_range(0, 2000));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(phase_scale[p], phase_col[p], phase_row[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        calm = (n < 25);                      // opening burst without idling
        if (p == 0 && n == 40) hold_go <= 1'b1;
        random_item();
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/hbs_pkg.sv
rtl/hbs_grid_mem.sv
rtl/heightmap_bilinear_sampler.sv
bench/hbs_checker.sv
bench/testbench.sv
